[hdl/ipcc_pkg.sv]
// Shared constants, the arctangent lookup and the queue status type for the
// iris polar coordinate check. No dependencies.
package ipcc_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int QUEUE_DEPTH         = 4;
  localparam int CORDIC_STEPS        = 24;
  localparam int ZW                  = 28;
  localparam int QUO_BITS            = 17;
  localparam int PADDR_W             = 3;

  localparam logic signed [ZW-1:0] PI_Q24     = 28'sd52707179;
  localparam logic signed [ZW-1:0] TWO_PI_Q24 = 28'sd105414357;

  localparam logic REG_RTOL = 1'b0;
  localparam logic REG_ATOL = 1'b1;

  localparam logic [14:0] RTOL_RST = 15'd1638;
  localparam logic [15:0] ATOL_RST = 16'd819;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/ipcc_front.sv]
// Front end: accepts input requests and forms the center-relative offsets.
// Depends on ipcc_pkg.
module ipcc_front #(
  parameter int CW = 16,
  parameter int IW = 6 * CW + 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [8*CW+31:0]       in_tdata,
  input  ipcc_pkg::q_stat_t      q_stat,
  output logic                   push,
  output logic [IW-1:0]          item
);
  import ipcc_pkg::*;

  logic              fv_r, fv_nxt;
  logic [IW-1:0]     item_r;
  logic [CW-1:0]     px, py, cx, cy, pr, ix, iy, ir;
  logic [CW:0]       dpx, dpy, dix, diy;
  logic              take;

  assign px = in_tdata[0*CW +: CW];
  assign py = in_tdata[1*CW +: CW];
  assign cx = in_tdata[2*CW +: CW];
  assign cy = in_tdata[3*CW +: CW];
  assign pr = in_tdata[4*CW +: CW];
  assign ix = in_tdata[5*CW +: CW];
  assign iy = in_tdata[6*CW +: CW];
  assign ir = in_tdata[7*CW +: CW];

  assign dpx = {1'b0, px} - {1'b0, cx};
  assign dpy = {1'b0, py} - {1'b0, cy};
  assign dix = {1'b0, px} - {1'b0, ix};
  assign diy = {1'b0, py} - {1'b0, iy};

  assign push      = fv_r && !q_stat.full;
  assign in_tready = !fv_r || !q_stat.full;
  assign take      = in_tvalid && in_tready;
  assign item      = item_r;

  always_comb begin
    fv_nxt = fv_r;
    if (take) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= {in_tdata[8*CW+31:8*CW], ir, pr, diy, dix, dpy, dpx};
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fv_r && q_stat.full) |=> (fv_r && $stable(item_r)))
    else $error("front item changed while the queue was full");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && fv_r && q_stat.full))
    else $error("front took a request with nowhere to put the held one");
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fv_r)
    else $error("front pushed without a held request");
`endif

endmodule

[hdl/ipcc_queue.sv]
// Short queue between the front end and the arithmetic back end.
// Depends on ipcc_pkg.
module ipcc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      wdata,
  input  logic              pop,
  output logic [W-1:0]      rdata,
  output ipcc_pkg::q_stat_t stat
);
  import ipcc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("queue read while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

[hdl/ipcc_back.sv]
// Back end: pipelined square roots, CORDIC, divider and tolerance compare.
// Depends on ipcc_pkg.
module ipcc_back #(
  parameter int CW = 16,
  parameter int AF = 13,
  parameter int IW = 6 * CW + 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IW-1:0]     item,
  input  ipcc_pkg::q_stat_t q_stat,
  output logic              pop,
  input  logic [14:0]       rtol,
  input  logic [15:0]       atol,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic              out_tuser
);
  import ipcc_pkg::*;

  localparam int RTW    = CW + 5;
  localparam int RADW   = 2 * RTW;
  localparam int CXW    = CW + 12;
  localparam int PW     = RTW + 2;
  localparam int DVW    = PW + 18;
  localparam int S_SQR  = 1;
  localparam int S_RAD  = 2;
  localparam int S_POS  = S_RAD + 1 + RTW;
  localparam int S_DSET = S_POS + 1;
  localparam int S_OVF  = S_DSET + 1;
  localparam int S_AFIX = S_RAD + CORDIC_STEPS;
  localparam int S_ARND = S_AFIX + 1;
  localparam int S_SAT  = (S_OVF + QUO_BITS + 1 > S_ARND + 1) ?
                          S_OVF + QUO_BITS + 1 : S_ARND + 1;
  localparam int S_CMP  = S_SAT + 1;
  localparam logic signed [ZW-1:0] CAP = TWO_PI_Q24 >>> (24 - AF);
  localparam logic signed [ZW-1:0] RND = ZW'(1) <<< (23 - AF);

  typedef struct packed {
    logic signed [CW:0]   dpx, dpy, dix, diy;
    logic [CW-1:0]        pr, ir;
    logic [15:0]          ref_r, ref_a;
    logic [2*CW-1:0]      sqa_p, sqb_p, sqa_i, sqb_i;
    logic [RADW-1:0]      rad_p, rad_i;
    logic [RTW+1:0]       rem_p, rem_i;
    logic [RTW-1:0]       root_p, root_i;
    logic signed [CXW-1:0] cx, cy;
    logic signed [ZW-1:0] cz;
    logic                 czero;
    logic signed [PW-1:0] ppos, den;
    logic [DVW-1:0]       drem;
    logic [PW:0]          dden;
    logic [QUO_BITS-1:0]  quo;
    logic                 ovf, neg, degen, sound;
    logic [15:0]          radial, ang;
  } st_t;

  function automatic logic [CW-1:0] mag_cw(input logic signed [CW:0] v);
    logic signed [CW:0] n;
    n = -v;
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  function automatic st_t step(input st_t a, input int idx,
                               input logic [14:0] rt, input logic [15:0] at);
    st_t                   b;
    logic [CW-1:0]         m0, m1, m2, m3;
    logic [2*CW:0]         s0, s1;
    logic [RTW+1:0]        r2, tr;
    logic signed [CXW-1:0] x0, y0, xs, ys;
    logic signed [PW-1:0]  ip, np, nd;
    logic [DVW-1:0]        sh;
    logic signed [ZW-1:0]  q;
    logic [QUO_BITS:0]     mg;
    logic signed [16:0]    dr, da;
    logic [16:0]           adr, ada;
    int                    k;
    b = a;
    if (idx == S_SQR) begin
      m0 = mag_cw(a.dpx);
      m1 = mag_cw(a.dpy);
      m2 = mag_cw(a.dix);
      m3 = mag_cw(a.diy);
      b.sqa_p = m0 * m0;
      b.sqb_p = m1 * m1;
      b.sqa_i = m2 * m2;
      b.sqb_i = m3 * m3;
      x0 = {{(CXW-CW-9){a.dpx[CW]}}, a.dpx, 8'b0};
      y0 = {{(CXW-CW-9){a.dpy[CW]}}, a.dpy, 8'b0};
      b.czero = (a.dpx == '0) && (a.dpy == '0);
      if (x0 < 0) begin
        b.cx = -x0;
        b.cy = -y0;
        b.cz = PI_Q24;
      end else begin
        b.cx = x0;
        b.cy = y0;
        b.cz = '0;
      end
    end
    if (idx == S_RAD) begin
      s0 = {1'b0, a.sqa_p} + {1'b0, a.sqb_p};
      s1 = {1'b0, a.sqa_i} + {1'b0, a.sqb_i};
      b.rad_p  = {1'b0, s0, 8'b0};
      b.rad_i  = {1'b0, s1, 8'b0};
      b.rem_p  = '0;
      b.rem_i  = '0;
      b.root_p = '0;
      b.root_i = '0;
    end
    if (idx > S_RAD && idx < S_POS) begin
      r2 = {a.rem_p[RTW-1:0], a.rad_p[RADW-1:RADW-2]};
      tr = {a.root_p, 2'b01};
      b.rad_p = {a.rad_p[RADW-3:0], 2'b00};
      if (r2 >= tr) begin
        b.rem_p  = r2 - tr;
        b.root_p = {a.root_p[RTW-2:0], 1'b1};
      end else begin
        b.rem_p  = r2;
        b.root_p = {a.root_p[RTW-2:0], 1'b0};
      end
      r2 = {a.rem_i[RTW-1:0], a.rad_i[RADW-1:RADW-2]};
      tr = {a.root_i, 2'b01};
      b.rad_i = {a.rad_i[RADW-3:0], 2'b00};
      if (r2 >= tr) begin
        b.rem_i  = r2 - tr;
        b.root_i = {a.root_i[RTW-2:0], 1'b1};
      end else begin
        b.rem_i  = r2;
        b.root_i = {a.root_i[RTW-2:0], 1'b0};
      end
    end
    if (idx == S_POS) begin
      b.ppos = {2'b00, a.root_p} - {3'b000, a.pr, 4'b0000};
      ip     = {3'b000, a.ir, 4'b0000} - {2'b00, a.root_i};
      b.den  = b.ppos + ip;
    end
    if (idx == S_DSET) begin
      np      = a.ppos[PW-1] ? -a.ppos : a.ppos;
      nd      = a.den[PW-1] ? -a.den : a.den;
      b.degen = (a.den == '0);
      b.neg   = a.ppos[PW-1] ^ a.den[PW-1];
      b.drem  = {3'b000, np, 15'b0} + {18'b0, nd};
      b.dden  = {nd, 1'b0};
    end
    if (idx == S_OVF) begin
      b.ovf = (a.drem >= {a.dden, 17'b0});
      b.quo = '0;
    end
    if (idx > S_OVF && idx <= S_OVF + QUO_BITS) begin
      k  = S_OVF + QUO_BITS - idx;
      sh = {a.dden, 17'b0} >> (QUO_BITS - k);
      if (a.drem >= sh) begin
        b.drem   = a.drem - sh;
        b.quo[k] = 1'b1;
      end
    end
    if (idx >= S_RAD && idx < S_AFIX) begin
      k  = idx - S_RAD;
      xs = a.cx >>> k;
      ys = a.cy >>> k;
      if (!a.cy[CXW-1]) begin
        b.cx = a.cx + ys;
        b.cy = a.cy - xs;
        b.cz = a.cz + atan_q24(k);
      end else begin
        b.cx = a.cx - ys;
        b.cy = a.cy + xs;
        b.cz = a.cz - atan_q24(k);
      end
    end
    if (idx == S_AFIX) begin
      if (a.cz < 0) begin
        b.cz = a.cz + TWO_PI_Q24;
      end
    end
    if (idx == S_ARND) begin
      q = (a.cz + RND) >>> (24 - AF);
      if (q > CAP) begin
        q = CAP;
      end
      b.ang = a.czero ? 16'd0 : q[15:0];
    end
    if (idx == S_SAT) begin
      mg = {a.ovf, a.quo};
      if (a.degen) begin
        b.radial = '0;
      end else if (a.neg) begin
        b.radial = (mg > 18'd32768) ? 16'h8000 : 16'(-mg);
      end else begin
        b.radial = (mg > 18'd32767) ? 16'h7FFF : mg[15:0];
      end
    end
    if (idx == S_CMP) begin
      dr  = {a.radial[15], a.radial} - {a.ref_r[15], a.ref_r};
      da  = {1'b0, a.ang} - {1'b0, a.ref_a};
      adr = dr[16] ? 17'(-dr) : dr;
      ada = da[16] ? 17'(-da) : da;
      b.sound = !a.degen && (adr <= {2'b00, rt}) && (ada <= {1'b0, at});
    end
    return b;
  endfunction

  st_t  st [S_CMP+1];
  logic v  [S_CMP+1];
  st_t  st0;
  logic adv;

  assign adv = !v[S_CMP] || out_tready;
  assign pop = adv && !q_stat.empty;

  always_comb begin
    st0       = '0;
    st0.dpx   = item[0*(CW+1) +: CW+1];
    st0.dpy   = item[1*(CW+1) +: CW+1];
    st0.dix   = item[2*(CW+1) +: CW+1];
    st0.diy   = item[3*(CW+1) +: CW+1];
    st0.pr    = item[4*(CW+1) +: CW];
    st0.ir    = item[4*(CW+1)+CW +: CW];
    st0.ref_r = item[4*(CW+1)+2*CW +: 16];
    st0.ref_a = item[4*(CW+1)+2*CW+16 +: 16];
  end

  assign st[0] = st0;
  assign v[0]  = !q_stat.empty;

  for (genvar s = 1; s <= S_CMP; s++) begin : g_stage
    st_t  st_r;
    logic v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r <= step(st[s-1], s, rtol, atol);
      end
    end
    assign st[s] = st_r;
    assign v[s]  = v_r;
  end

  assign out_tvalid = v[S_CMP];
  assign out_tdata  = {7'b0, st[S_CMP].sound, st[S_CMP].ang, st[S_CMP].radial};
  assign out_tuser  = st[S_CMP].degen;

`ifndef ASSERT_OFF
  a_degen_unsound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tdata[32])
    else $error("degenerate result marked sound");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[15:0] == 16'd0))
    else $error("degenerate result with nonzero radial position");
  a_angle_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({{(ZW-16){1'b0}}, out_tdata[31:16]} <= CAP || AF > 13))
    else $error("angle above the cap");
`endif

endmodule

[hdl/iris_polar_coordinate_check_core.sv]
// Top level of the iris polar coordinate check: configuration registers,
// front end, queue and arithmetic back end. Depends on ipcc_pkg and submodules.
//
// Each request gives one result. The block takes a new request every clock
// cycle while the queue is not full and produces one result per cycle when
// the output is not stalled. A request passes through the front register,
// the queue and COORD_WIDTH + 29 back-end stages, set by the bit-per-stage
// square roots followed by the bit-per-stage quotient pipeline; the CORDIC
// runs alongside the square roots. A stalled output holds the back pipeline
// while the front end keeps filling a four-entry queue.
module iris_polar_coordinate_check_core #(
  parameter int COORD_WIDTH     = ipcc_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ipcc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // point_x, point_y, pupil_x, pupil_y, pupil_radius, iris_x, iris_y,
  // iris_radius, ref_radius, ref_angle
  input  logic [8*COORD_WIDTH+31:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // radial_position, angle, sound, zero fill
  output logic [39:0]                   out_tdata,
  // degenerate
  output logic                          out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ipcc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import ipcc_pkg::*;

  localparam int IW = 6 * COORD_WIDTH + 36;

  logic [14:0]   rtol_r;
  logic [15:0]   atol_r;
  logic          wr;
  logic          push, pop;
  logic [IW-1:0] f_item, q_item;
  q_stat_t       q_stat;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtol_r <= RTOL_RST;
      atol_r <= ATOL_RST;
    end else if (wr) begin
      unique case (cfg_paddr[2])
        REG_RTOL: rtol_r <= cfg_pwdata[14:0];
        REG_ATOL: atol_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_RTOL: cfg_prdata = {17'b0, rtol_r};
      REG_ATOL: cfg_prdata = {16'b0, atol_r};
      default:  cfg_prdata = '0;
    endcase
  end

  ipcc_front #(.CW(COORD_WIDTH), .IW(IW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .item      (f_item)
  );

  ipcc_queue #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (q_item),
    .stat  (q_stat)
  );

  ipcc_back #(.CW(COORD_WIDTH), .AF(ANGLE_FRAC_BITS), .IW(IW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .q_stat     (q_stat),
    .pop        (pop),
    .rtol       (rtol_r),
    .atol       (atol_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
